/* src/yaz_pkg.sv */
// Shared types, constants and helpers for the Yaz0 stream decompressor.
package yaz_pkg;

   localparam int DATA_W  = 64;
   localparam int COUNT_W = 4;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_BAD_MAGIC = 2'd1;
   localparam status_type ST_TRUNC     = 2'd2;
   localparam status_type ST_BAD_REF   = 2'd3;

   localparam logic [3:0] HDR_SIZE_FIRST = 4'd4;
   localparam logic [3:0] HDR_SIZE_END   = 4'd8;
   localparam logic [3:0] HDR_LAST       = 4'h0F;
   localparam logic [8:0] SHORT_BIAS     = 9'd2;
   localparam logic [8:0] LONG_BIAS      = 9'h012;
   localparam logic [3:0] FLAG_GROUP     = 4'd8;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      unique case (idx)
         2'd0: m = 8'h59;   // Y
         2'd1: m = 8'h61;   // a
         2'd2: m = 8'h7A;   // z
         default: m = 8'h30; // 0
      endcase
      return m;
   endfunction

endpackage

/* src/yaz_if.sv */
// Valid/ready channel interfaces for the compressed input and decoded output.
interface yaz_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface yaz_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [yaz_pkg::DATA_W-1:0]  out_data;
   logic [yaz_pkg::COUNT_W-1:0] out_count;
   logic                        out_last;
   logic                        out_done;
   yaz_pkg::status_type         out_status;

   modport source (output valid, output out_data, output out_count, output out_last,
                   output out_done, output out_status, input ready);
   modport sink (input valid, input out_data, input out_count, input out_last,
                 input out_done, input out_status, output ready);
endinterface

/* src/yaz_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module yaz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/yaz0_stream_decompressor.sv */
// Yaz0 stream decompressor: header check, flag/token parser, window copy engine, packer.
// A header, flag, token or literal byte yields its single result in the cycle after
//   acceptance; one input byte per cycle while the result register drains.
// A back-reference copies each byte by a window RAM read and then a write-back;
//   results leave every OUT_LANES bytes and at its end; input is held until the copy ends.
// Reset (synchronous) clears the parser, counters and output; window contents are
//   undefined after reset and need no clearing pass.
module yaz0_stream_decompressor #(
   parameter int WINDOW_BYTES = 4096,
   parameter int OUT_LANES    = 8
) (
   input  logic      clock,
   input  logic      reset,
   yaz_req_if.sink   req_ch,
   yaz_rsp_if.source rsp_ch
);

   localparam int WIN_AW = $clog2(WINDOW_BYTES);

   localparam logic [2:0] P_HEADER = 3'd0;
   localparam logic [2:0] P_FLAG   = 3'd1;
   localparam logic [2:0] P_LIT    = 3'd2;
   localparam logic [2:0] P_REF1   = 3'd3;
   localparam logic [2:0] P_REF2   = 3'd4;
   localparam logic [2:0] P_REF3   = 3'd5;
   localparam logic [2:0] P_STOP   = 3'd6;

   localparam logic [1:0] S_IN = 2'd0;
   localparam logic [1:0] S_RD = 2'd1;
   localparam logic [1:0] S_WR = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [31:0] exp_ff, exp_in;
   logic [31:0] prod_ff, prod_in;
   logic [7:0]  flag_ff, flag_in;
   logic [3:0]  bits_ff, bits_in;
   logic [7:0]  ref1_ff, ref1_in;
   logic [7:0]  ref2_ff, ref2_in;
   yaz_pkg::status_type err_ff, err_in;

   logic [WIN_AW-1:0] src_ff, src_in;
   logic [8:0]        left_ff, left_in;
   logic              step_done_ff, step_done_in;
   yaz_pkg::status_type step_status_ff, step_status_in;

   logic [yaz_pkg::DATA_W-1:0]  pack_data_ff, pack_data_in;
   logic [yaz_pkg::COUNT_W-1:0] pack_cnt_ff, pack_cnt_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [yaz_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [yaz_pkg::COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_done_ff, rsp_done_in;
   yaz_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic        out_free;
   logic        accept;
   logic [7:0]  in_b;
   logic        lit;
   logic        want_copy;
   logic        go_copy;
   logic [8:0]  len;
   logic [11:0] ref_dist;
   logic [31:0] rem;
   logic [8:0]  run_n;
   logic [31:0] prod_fin;
   logic        done_now;

   logic        copy_adv;
   logic        copy_final;
   logic        lane_full;
   logic        emit;
   logic [7:0]  copy_b;
   logic [yaz_pkg::DATA_W-1:0] merged;

   logic              ram_we;
   logic [WIN_AW-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [7:0]        ram_rdata;

   function automatic logic [2:0] next_tok(input logic [31:0] prod, input logic [31:0] expv,
                                          input logic [3:0] bits, input logic [7:0] flag);
      logic [2:0] p;
      if (prod == expv) begin
         p = P_STOP;
      end else if (bits == 4'd0) begin
         p = P_FLAG;
      end else begin
         p = flag[7] ? P_LIT : P_REF1;
      end
      return p;
   endfunction

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IN) && out_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_b         = req_ch.in_byte;

   // Window: literal writes on accept, copy bytes write back in the S_WR step.
   yaz_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_BYTES)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (src_ff),
      .rdata (ram_rdata)
   );

   assign copy_b     = ram_rdata;
   assign copy_final = (left_ff == 9'd1);
   assign lane_full  = (pack_cnt_ff + 4'd1) == 4'(OUT_LANES);
   assign emit       = copy_final || lane_full;
   // Interlock: hold the read data until the result register can take a packed word.
   assign copy_adv   = (state_ff == S_WR) && (!emit || out_free);

   assign ram_re    = (state_ff == S_RD);
   assign ram_we    = (accept && lit) || copy_adv;
   assign ram_waddr = prod_ff[WIN_AW-1:0];
   assign ram_wdata = copy_adv ? copy_b : in_b;

   always_comb begin
      merged = pack_data_ff;
      for (int i = 0; i < 8; i++) begin
         if (i < OUT_LANES && pack_cnt_ff == 4'(i)) begin
            merged[8*i +: 8] = copy_b;
         end
      end
   end

   assign rem      = exp_ff - prod_ff;
   assign run_n    = (rem < {23'd0, len}) ? rem[8:0] : len;
   assign prod_fin = prod_ff + {23'd0, run_n};

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      hdr_idx_in     = hdr_idx_ff;
      exp_in         = exp_ff;
      prod_in        = prod_ff;
      flag_in        = flag_ff;
      bits_in        = bits_ff;
      ref1_in        = ref1_ff;
      ref2_in        = ref2_ff;
      err_in         = err_ff;
      src_in         = src_ff;
      left_in        = left_ff;
      step_done_in   = step_done_ff;
      step_status_in = step_status_ff;
      pack_data_in   = pack_data_ff;
      pack_cnt_in    = pack_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in    = rsp_data_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_status_in  = rsp_status_ff;
      lit            = 1'b0;
      want_copy      = 1'b0;
      go_copy        = 1'b0;
      len            = 9'd0;
      ref_dist       = 12'd0;
      done_now       = 1'b0;

      unique case (state_ff)
         S_IN: begin
            if (accept) begin
               unique case (phase_ff)
                  P_HEADER: begin
                     if (hdr_idx_ff < yaz_pkg::HDR_SIZE_FIRST &&
                         in_b != yaz_pkg::magic_byte(hdr_idx_ff[1:0])) begin
                        err_in   = yaz_pkg::ST_BAD_MAGIC;
                        phase_in = P_STOP;
                     end else begin
                        if (hdr_idx_ff >= yaz_pkg::HDR_SIZE_FIRST &&
                            hdr_idx_ff < yaz_pkg::HDR_SIZE_END) begin
                           exp_in = {exp_ff[23:0], in_b};
                        end
                        if (hdr_idx_ff == yaz_pkg::HDR_LAST) begin
                           bits_in  = 4'd0;
                           phase_in = next_tok(prod_ff, exp_in, 4'd0, flag_ff);
                        end else begin
                           hdr_idx_in = hdr_idx_ff + 4'd1;
                        end
                     end
                  end
                  P_FLAG: begin
                     flag_in  = in_b;
                     bits_in  = yaz_pkg::FLAG_GROUP;
                     phase_in = in_b[7] ? P_LIT : P_REF1;
                  end
                  P_LIT: begin
                     lit      = 1'b1;
                     prod_in  = prod_ff + 32'd1;
                     flag_in  = {flag_ff[6:0], 1'b0};
                     bits_in  = (bits_ff != 4'd0) ? bits_ff - 4'd1 : bits_ff;
                     phase_in = next_tok(prod_in, exp_ff, bits_in, flag_in);
                  end
                  P_REF1: begin
                     ref1_in  = in_b;
                     phase_in = P_REF2;
                  end
                  P_REF2: begin
                     ref2_in = in_b;
                     if (ref1_ff[7:4] == 4'd0) begin
                        phase_in = P_REF3;
                     end else begin
                        want_copy = 1'b1;
                        len       = {5'd0, ref1_ff[7:4]} + yaz_pkg::SHORT_BIAS;
                        ref_dist  = {ref1_ff[3:0], in_b};
                     end
                  end
                  P_REF3: begin
                     want_copy = 1'b1;
                     len       = {1'b0, in_b} + yaz_pkg::LONG_BIAS;
                     ref_dist  = {ref1_ff[3:0], ref2_ff};
                  end
                  P_STOP: begin
                  end
                  default: begin
                  end
               endcase

               if (want_copy) begin
                  if ({20'd0, ref_dist} >= prod_ff) begin
                     err_in   = yaz_pkg::ST_BAD_REF;
                     phase_in = P_STOP;
                  end else begin
                     go_copy  = 1'b1;
                     flag_in  = {flag_ff[6:0], 1'b0};
                     bits_in  = (bits_ff != 4'd0) ? bits_ff - 4'd1 : bits_ff;
                     phase_in = next_tok(prod_fin, exp_ff, bits_in, flag_in);
                  end
               end

               if (req_ch.in_last && phase_in != P_STOP) begin
                  err_in   = yaz_pkg::ST_TRUNC;
                  phase_in = P_STOP;
               end

               done_now = (phase_in != P_HEADER) && (hdr_idx_in == yaz_pkg::HDR_LAST) &&
                          (err_in == yaz_pkg::ST_OK) &&
                          ((go_copy ? prod_fin : prod_in) == exp_in);

               if (go_copy) begin
                  state_in       = S_RD;
                  src_in         = prod_ff[WIN_AW-1:0] - ref_dist[WIN_AW-1:0] - WIN_AW'(1);
                  left_in        = run_n;
                  step_done_in   = done_now;
                  step_status_in = err_in;
                  pack_data_in   = '0;
                  pack_cnt_in    = '0;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = lit ? {56'd0, in_b} : '0;
                  rsp_cnt_in    = lit ? 4'd1 : 4'd0;
                  rsp_last_in   = 1'b1;
                  rsp_done_in   = done_now;
                  rsp_status_in = err_in;
               end
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            if (copy_adv) begin
               prod_in  = prod_ff + 32'd1;
               src_in   = src_ff + WIN_AW'(1);
               left_in  = left_ff - 9'd1;
               state_in = copy_final ? S_IN : S_RD;
               if (emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = merged;
                  rsp_cnt_in    = pack_cnt_ff + 4'd1;
                  rsp_last_in   = copy_final;
                  rsp_done_in   = step_done_ff;
                  rsp_status_in = step_status_ff;
                  pack_data_in  = '0;
                  pack_cnt_in   = '0;
               end else begin
                  pack_data_in = merged;
                  pack_cnt_in  = pack_cnt_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = S_IN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IN;
         phase_ff     <= P_HEADER;
         hdr_idx_ff   <= '0;
         exp_ff       <= '0;
         prod_ff      <= '0;
         flag_ff      <= '0;
         bits_ff      <= '0;
         ref1_ff      <= '0;
         ref2_ff      <= '0;
         err_ff       <= yaz_pkg::ST_OK;
         left_ff      <= '0;
         pack_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         exp_ff       <= exp_in;
         prod_ff      <= prod_in;
         flag_ff      <= flag_in;
         bits_ff      <= bits_in;
         ref1_ff      <= ref1_in;
         ref2_ff      <= ref2_in;
         err_ff       <= err_in;
         left_ff      <= left_in;
         pack_cnt_ff  <= pack_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff         <= src_in;
      step_done_ff   <= step_done_in;
      step_status_ff <= step_status_in;
      pack_data_ff   <= pack_data_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_cnt_ff     <= rsp_cnt_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_data   = rsp_data_ff;
   assign rsp_ch.out_count  = rsp_cnt_ff;
   assign rsp_ch.out_last   = rsp_last_ff;
   assign rsp_ch.out_done   = rsp_done_ff;
   assign rsp_ch.out_status = rsp_status_ff;

   a_copy_within_size: assert property (@(posedge clock) disable iff (reset)
      copy_adv |-> prod_ff < exp_ff)
      else $error("copy wrote past the stated size");

   a_partial_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> rsp_cnt_ff == 4'(OUT_LANES))
      else $error("partial word sent before end of transaction");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      (err_ff != yaz_pkg::ST_OK) |=> err_ff == $past(err_ff))
      else $error("error code changed once raised");

   a_copy_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_WR) |-> left_ff != 9'd0)
      else $error("copy engine running with nothing left");

endmodule

/* dv/yaz_decode_monitor.sv */
// Decode predictor and result checker for the Yaz0 stream decompressor.
module yaz_decode_monitor (
   input  logic clock,
   input  logic reset,
   yaz_req_if   req_ch,
   yaz_rsp_if   rsp_ch,
   output int   fail_count,
   output int   pending_words
);

   localparam int          LANES          = 8;
   localparam int          RUN_BIAS_SHORT = 2;
   localparam int          RUN_BIAS_LONG  = 18;
   localparam logic [3:0]  HEADER_END     = 4'd15;
   localparam logic [31:0] MAGIC_WORD     = "Yaz0";

   typedef enum logic [2:0] {
      P_HEADER, P_FLAG, P_LIT, P_REF1, P_REF2, P_REF3, P_STOP
   } parse_phase_type;

   typedef struct packed {
      logic [yaz_pkg::DATA_W-1:0]  data;
      logic [yaz_pkg::COUNT_W-1:0] count;
      logic                        last;
      logic                        done;
      yaz_pkg::status_type         status;
   } out_word_type;

   out_word_type        expected_words[$];
   logic [7:0]          window_mem [0:4095];
   logic [7:0]          run_bytes[$];
   parse_phase_type     phase;
   logic [3:0]          hdr_pos;
   logic [31:0]         stated_size;
   logic [31:0]         out_total;
   logic [7:0]          flags;
   logic [3:0]          flags_left;
   logic [7:0]          ref_hi;
   logic [7:0]          ref_lo;
   yaz_pkg::status_type status;

   function automatic bit stream_done();
      return phase != P_HEADER && hdr_pos == HEADER_END && status == yaz_pkg::ST_OK &&
             out_total == stated_size;
   endfunction

   task automatic emit_byte(input logic [7:0] b);
      window_mem[out_total[11:0]] = b;
      out_total++;
      run_bytes.insert(run_bytes.size(), b);
   endtask

   task automatic pick_next();
      if (out_total == stated_size) phase = P_STOP;
      else if (flags_left == 0) phase = P_FLAG;
      else phase = flags[7] ? P_LIT : P_REF1;
   endtask

   task automatic finish_token();
      flags = flags << 1;
      if (flags_left > 0) flags_left--;
      pick_next();
   endtask

   task automatic copy_back(input int len);
      int          ref_dist;
      logic [31:0] src;
      ref_dist = {ref_hi[3:0], ref_lo};
      if (ref_dist + 1 > out_total) begin
         status = yaz_pkg::ST_BAD_REF;
         phase = P_STOP;
         return;
      end
      // overlapping copies read bytes written earlier in this same loop
      for (int i = 0; i < len && out_total < stated_size; i++) begin
         src = out_total - ref_dist - 1;
         emit_byte(window_mem[src[11:0]]);
      end
      finish_token();
   endtask

   task automatic take_byte(input logic [7:0] b);
      case (phase)
         P_HEADER: begin
            if (hdr_pos < 4) begin
               if (b != MAGIC_WORD[31 - 8*hdr_pos -: 8]) begin
                  status = yaz_pkg::ST_BAD_MAGIC;
                  phase = P_STOP;
                  return;
               end
            end else if (hdr_pos < 8) begin
               stated_size = {stated_size[23:0], b};
            end
            if (hdr_pos == HEADER_END) begin
               flags_left = '0;
               pick_next();
            end else begin
               hdr_pos++;
            end
         end
         P_FLAG: begin
            flags = b;
            flags_left = 4'd8;
            phase = b[7] ? P_LIT : P_REF1;
         end
         P_LIT: begin
            emit_byte(b);
            finish_token();
         end
         P_REF1: begin
            ref_hi = b;
            phase = P_REF2;
         end
         P_REF2: begin
            ref_lo = b;
            if (ref_hi[7:4] == 4'd0) phase = P_REF3;
            else copy_back(ref_hi[7:4] + RUN_BIAS_SHORT);
         end
         P_REF3: copy_back(b + RUN_BIAS_LONG);
         default: ;
      endcase
   endtask

   task automatic decode_step(input logic [7:0] b, input logic last);
      out_word_type w;
      int           n_words;
      int           pos;
      int           lane;
      run_bytes.delete();
      if (phase != P_STOP) take_byte(b);
      if (last && phase != P_STOP) begin
         if (!stream_done() && status == yaz_pkg::ST_OK) status = yaz_pkg::ST_TRUNC;
         phase = P_STOP;
      end
      n_words = (run_bytes.size() + LANES - 1) / LANES;
      if (n_words == 0) n_words = 1;
      pos = 0;
      for (int k = 0; k < n_words; k++) begin
         w = '0;
         lane = 0;
         while (lane < LANES && pos < run_bytes.size()) begin
            w.data[8*lane +: 8] = run_bytes[pos];
            lane++;
            pos++;
         end
         w.count = 4'(lane);
         w.last = (k == n_words - 1);
         w.done = stream_done();
         w.status = status;
         expected_words.insert(expected_words.size(), w);
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic check_word();
      out_word_type want;
      if (expected_words.size() == 0) begin
         fail_count++;
         $display("%0t: result with nothing expected, actual data %h count %0d last %0b",
                  $time, rsp_ch.out_data, rsp_ch.out_count, rsp_ch.out_last);
         return;
      end
      want = expected_words.pop_front();
      compare_field("out_data", want.data, rsp_ch.out_data);
      compare_field("out_count", 64'(want.count), 64'(rsp_ch.out_count));
      compare_field("out_last", 64'(want.last), 64'(rsp_ch.out_last));
      compare_field("out_done", 64'(want.done), 64'(rsp_ch.out_done));
      compare_field("out_status", 64'(want.status), 64'(rsp_ch.out_status));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = P_HEADER;
         hdr_pos = '0;
         stated_size = '0;
         out_total = '0;
         flags = '0;
         flags_left = '0;
         ref_hi = '0;
         ref_lo = '0;
         status = yaz_pkg::ST_OK;
         expected_words.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) decode_step(req_ch.in_byte, req_ch.in_last);
         if (rsp_ch.valid && rsp_ch.ready) check_word();
      end
      pending_words = expected_words.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top for the Yaz0 stream decompressor: stream generation, handshakes and verdict.
module tb;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int BODY_BUDGET    = 245;
   localparam int TAIL_BYTES     = 12;
   localparam int IDLE_PERCENT   = 36;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_OFF       = 400;
   localparam int STEADY_RX      = 1000;
   localparam int RUN_BIAS_SHORT = 2;
   localparam int RUN_BIAS_LONG  = 18;

   typedef enum int {
      RUN_FULL, RUN_TRUNC, RUN_BAD_REF, RUN_BAD_MAGIC, RUN_ZERO_SIZE
   } run_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   int         fail_count;
   int         pending_words;
   int         cycle_count = 0;
   int         sent_count = 0;

   logic [7:0] body_bytes[$];
   logic [7:0] group_bytes[$];
   logic [7:0] group_flags;
   int         group_n;
   int         decoded_len;
   logic [7:0] stream_bytes[$];
   logic       stream_last[$];

   yaz_req_if req_if();
   yaz_rsp_if rsp_if();

   yaz0_stream_decompressor uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   yaz_decode_monitor decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_if),
      .rsp_ch        (rsp_if),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int body_size();
      return body_bytes.size() + group_bytes.size() + (group_n != 0);
   endfunction

   function automatic int reach_limit();
      return (decoded_len > 4096) ? 4096 : decoded_len;
   endfunction

   task automatic flush_group();
      if (group_n == 0) return;
      // unused flag bits are never reached, so fill them with noise
      for (int k = group_n; k < 8; k++) group_flags[7 - k] = 1'($urandom_range(0, 1));
      body_bytes.insert(body_bytes.size(), group_flags);
      foreach (group_bytes[k]) body_bytes.insert(body_bytes.size(), group_bytes[k]);
      group_bytes.delete();
      group_flags = '0;
      group_n = 0;
   endtask

   task automatic close_slot();
      group_n++;
      if (group_n == 8) flush_group();
   endtask

   task automatic put_literal(input logic [7:0] b);
      group_flags[7 - group_n] = 1'b1;
      group_bytes.insert(group_bytes.size(), b);
      decoded_len++;
      close_slot();
   endtask

   task automatic put_copy(input int ref_dist, input int len);
      logic [11:0] code;
      logic [3:0]  nib;
      logic [7:0]  extra;
      code = 12'(ref_dist);
      if (len < RUN_BIAS_LONG) begin
         nib = 4'(len - RUN_BIAS_SHORT);
         group_bytes.insert(group_bytes.size(), {nib, code[11:8]});
         group_bytes.insert(group_bytes.size(), code[7:0]);
      end else begin
         extra = 8'(len - RUN_BIAS_LONG);
         group_bytes.insert(group_bytes.size(), {4'h0, code[11:8]});
         group_bytes.insert(group_bytes.size(), code[7:0]);
         group_bytes.insert(group_bytes.size(), extra);
      end
      decoded_len += len;
      close_slot();
   endtask

   task automatic put_random_copy(input bit keep_short);
      int reach;
      int ref_dist;
      int len;
      int pick;
      reach = reach_limit();
      case ($urandom_range(0, 3))
         0: ref_dist = 0;
         1: ref_dist = reach - 1;
         default: ref_dist = $urandom_range(0, reach - 1);
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 5) len = $urandom_range(3, 17);
      else if (pick == 5) len = 18;
      else if (pick == 6) len = 273;
      else len = $urandom_range(18, 273);
      // keep the output below the window so a far reference still misses
      if (keep_short && len > 40) len = $urandom_range(18, 40);
      put_copy(ref_dist, len);
   endtask

   task automatic compose_stream(input run_kind_type kind);
      logic [31:0] size_word;
      int          final_len;
      int          prior_len;
      int          cut;
      group_flags = '0;
      group_n = 0;
      decoded_len = 0;
      // openers: literal extremes, overlapping runs, both copy forms at their limits
      put_literal(8'h00);
      put_literal(8'hFF);
      put_copy(0, 3);
      put_copy(1, 17);
      put_copy(0, 18);
      put_copy(1, 273);
      while (body_size() < BODY_BUDGET) begin
         if (decoded_len == 0 || $urandom_range(0, 99) < 40)
            put_literal(8'($urandom_range(0, 255)));
         else
            put_random_copy(kind == RUN_BAD_REF);
      end
      prior_len = decoded_len;
      if (kind == RUN_BAD_REF) begin
         put_copy($urandom_range(decoded_len, 4095), $urandom_range(3, 273));
         size_word = decoded_len + 1000;
      end else begin
         // last copy may run past the stated size and then gets cut
         final_len = $urandom_range(18, 273);
         put_copy($urandom_range(0, reach_limit() - 1), final_len);
         size_word = prior_len + $urandom_range(1, final_len);
      end
      flush_group();
      if (kind == RUN_TRUNC) size_word = decoded_len + 1 + $urandom_range(0, 32'h0FFF_FFFF);
      if (kind == RUN_ZERO_SIZE) size_word = '0;

      for (int k = 0; k < 4; k++)
         stream_bytes.insert(stream_bytes.size(), yaz_pkg::magic_byte(2'(k)));
      if (kind == RUN_BAD_MAGIC) begin
         cut = $urandom_range(0, 3);
         stream_bytes[cut] = stream_bytes[cut] ^ 8'($urandom_range(1, 255));
      end
      for (int k = 3; k >= 0; k--)
         stream_bytes.insert(stream_bytes.size(), size_word[8*k +: 8]);
      stream_bytes.insert(stream_bytes.size(), 8'h00);
      stream_bytes.insert(stream_bytes.size(), 8'hFF);
      repeat (6) stream_bytes.insert(stream_bytes.size(), 8'($urandom_range(0, 255)));
      foreach (body_bytes[k]) stream_bytes.insert(stream_bytes.size(), body_bytes[k]);
      foreach (stream_bytes[k]) stream_last.insert(stream_last.size(), 1'b0);
      if (kind == RUN_TRUNC) begin
         cut = $urandom_range(8, stream_bytes.size() - 1);
         while (stream_bytes.size() > cut + 1) begin
            void'(stream_bytes.pop_back());
            void'(stream_last.pop_back());
         end
      end
      stream_last[stream_last.size() - 1] = 1'b1;
      // everything after the end is ignored by the block
      repeat (TAIL_BYTES) begin
         stream_bytes.insert(stream_bytes.size(), 8'($urandom_range(0, 255)));
         stream_last.insert(stream_last.size(), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic offer_byte(input logic [7:0] b, input logic last, input bit gaps);
      while (gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= last;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      @(posedge clock);
   endtask

   initial begin
      run_kind_type kind;
      int           pick;
      req_if.valid <= 1'b0;
      req_if.in_byte <= '0;
      req_if.in_last <= 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 55) kind = RUN_FULL;
      else if (pick < 75) kind = RUN_TRUNC;
      else if (pick < 85) kind = RUN_BAD_REF;
      else if (pick < 93) kind = RUN_BAD_MAGIC;
      else kind = RUN_ZERO_SIZE;
      compose_stream(kind);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < stream_bytes.size(); i++) begin
         if (i == 30 || i == 200) hold_until_drained();
         offer_byte(stream_bytes[i], stream_last[i], i < 100 || i >= 180);
      end
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      int hold_left;
      int steady_left;
      bit held;
      rsp_if.ready <= 1'b0;
      hold_left = 0;
      steady_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sent_count >= 16) begin
            held = 1'b1;
            hold_left = HOLD_OFF;
            steady_left = STEADY_RX;
         end
         // long hold-off: let the block fill and stall its input, then drain steadily
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (steady_left > 0) begin
            steady_left--;
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

endmodule
